[src/mexp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg - shared types and constants of the modular exponentiation block
// Field widths, register reset values, register indexes and the control and
// status groups passed between the top level and the core.
// ----------------------------------------------------------------------------
package mexp_pkg;

   localparam int unsigned LOW_BITS     = 64;
   localparam int unsigned HIGH_BITS    = 32;
   localparam int unsigned OPERAND_BITS = LOW_BITS + HIGH_BITS;
   localparam int unsigned CSR_INDEX_BITS = 2;

   localparam logic [LOW_BITS-1:0]  MODULUS_LOW_RESET  = 64'hd;
   localparam logic [HIGH_BITS-1:0] MODULUS_HIGH_RESET = 32'h10000;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MODULUS_LOW  = 2'd0,
      CSR_MODULUS_HIGH = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic start;   // new operand set, core idle
      logic take;    // finished result moved to the output register
   } core_ctrl_type;

   typedef struct packed {
      logic idle;
      logic done;
      logic error;   // modulus was zero
   } core_stat_type;

endpackage
`default_nettype wire

[src/modular_exponentiation_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation_top - 96-bit modular power, base^exponent mod modulus
// Holds the modulus registers and the output register around the core.
//
//   channel  direction  handshake            payload
//   req_     in         req_tvalid/tready    tdata: base, exponent
//   rsp_     out        rsp_tvalid/tready    tdata: result, tuser: modulus_error
//   csr_     in         csr_valid/ready      csr_index, csr_wdata
//
// one transaction runs per exponent bit up to two multiplies, each a
// bit-serial loop on the shared adder followed by a bit-serial reduction
// in the core. a zero modulus skips the loops: the core goes straight to
// its done state, from which the result is registered into the output
// register.
// synchronous reset; req_tready is low from acceptance until the core hands
// its result to the output register, which waits on rsp_tready.
// ----------------------------------------------------------------------------
module modular_exponentiation_top import mexp_pkg::*; #(
   parameter int unsigned MODULUS_WORDS = 3
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // base_low, base_high, exponent_low, exponent_high
   input  wire logic [2*OPERAND_BITS-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // result_low, result_high
   output logic      [OPERAND_BITS-1:0]     rsp_tdata,
   // modulus_error
   output logic      [0:0]                  rsp_tuser,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [LOW_BITS-1:0]         csr_wdata
);

   logic [LOW_BITS-1:0]     mod_low_ff, mod_low_in;
   logic [HIGH_BITS-1:0]    mod_high_ff, mod_high_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OPERAND_BITS-1:0] rsp_data_ff;
   logic                    rsp_err_ff;

   core_ctrl_type           core_ctrl;
   core_stat_type           core_stat;
   logic [OPERAND_BITS-1:0] core_result;
   logic                    csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      mod_low_in  = mod_low_ff;
      mod_high_in = mod_high_ff;
      if (csr_write) begin
         priority if (csr_index == CSR_MODULUS_LOW) begin
            mod_low_in = csr_wdata;
         end else if (csr_index == CSR_MODULUS_HIGH) begin
            mod_high_in = csr_wdata[HIGH_BITS-1:0];
         end else begin
            // unmapped index, write dropped
            mod_low_in = mod_low_ff;
         end
      end
   end

   assign req_tready     = core_stat.idle;
   assign core_ctrl.start = req_tvalid && req_tready;
   assign core_ctrl.take  = core_stat.done && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (core_ctrl.take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   mexp_core #(
      .MODULUS_WORDS(MODULUS_WORDS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (core_ctrl),
      .base    (req_tdata[OPERAND_BITS-1:0]),
      .exponent(req_tdata[2*OPERAND_BITS-1:OPERAND_BITS]),
      .modulus ({mod_high_ff, mod_low_ff}),
      .stat    (core_stat),
      .result  (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_low_ff   <= MODULUS_LOW_RESET;
         mod_high_ff  <= MODULUS_HIGH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         mod_low_ff   <= mod_low_in;
         mod_high_ff  <= mod_high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (core_ctrl.take) begin
         rsp_data_ff <= core_result;
         rsp_err_ff  <= core_stat.error;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_err_ff;

   // an accepted transaction keeps the block busy in the cycle after acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted twice in a row");

   a_error_result_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("modulus error with nonzero result");

   a_done_not_ready: assert property (@(posedge clock) disable iff (reset)
      core_stat.done |-> !req_tready)
      else $error("ready while a result is pending in the core");

   a_take_shows_result: assert property (@(posedge clock) disable iff (reset)
      core_ctrl.take |=> rsp_tvalid)
      else $error("result handed over but not presented");

endmodule
`default_nettype wire

[src/mexp_alu.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_alu - shared wide adder / subtractor
// Adds b to a, or subtracts it, and returns the carry out; on a subtract the
// carry is set when a is not below b.
// ----------------------------------------------------------------------------
module mexp_alu #(
   parameter int unsigned WIDTH = 192
) (
   input  wire logic [WIDTH-1:0] a,
   input  wire logic [WIDTH-1:0] b,
   input  wire logic             sub,
   output logic      [WIDTH-1:0] sum,
   output logic                  carry
);

   logic [WIDTH:0]   total;
   logic [WIDTH-1:0] b_eff;

   assign b_eff = sub ? ~b : b;
   assign total = {1'b0, a} + {1'b0, b_eff} + {{WIDTH{1'b0}}, sub};
   assign sum   = total[WIDTH-1:0];
   assign carry = total[WIDTH];

endmodule
`default_nettype wire

[src/mexp_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_core - square-and-multiply sequencer
// Runs the base reduction, then per exponent bit an optional multiply into the
// accumulator and a squaring, each a shift-and-add multiply followed by a
// restoring shift-subtract reduction, all on one shared adder.
// ----------------------------------------------------------------------------
module mexp_core import mexp_pkg::*; #(
   parameter int unsigned MODULUS_WORDS = 3
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire core_ctrl_type           ctrl,
   input  wire logic [OPERAND_BITS-1:0] base,
   input  wire logic [OPERAND_BITS-1:0] exponent,
   input  wire logic [OPERAND_BITS-1:0] modulus,
   output core_stat_type                stat,
   output logic      [OPERAND_BITS-1:0] result
);

   localparam int unsigned W      = MODULUS_WORDS * 32;
   localparam int unsigned WW     = 2 * W;
   localparam int unsigned STEP_W = $clog2(W + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_RED,
      ST_WBACK,
      ST_CHOOSE,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [WW-1:0]     x_ff, x_in;
   logic [WW-1:0]     acc_ff, acc_in;
   logic [WW-1:0]     sb_ff, sb_in;
   logic [W-1:0]      exp_ff, exp_in;
   logic [WW-1:0]     mcand_ff, mcand_in;
   logic [WW-1:0]     mplier_ff, mplier_in;
   logic [WW-1:0]     div_ff, div_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              dest_acc_ff, dest_acc_in;
   logic              first_ff, first_in;
   logic              acc_done_ff, acc_done_in;
   logic              err_ff, err_in;

   logic [W-1:0]      mod_w;
   logic [WW-1:0]     alu_b;
   logic [WW-1:0]     alu_sum;
   logic              alu_sub;
   logic              alu_carry;

   assign mod_w   = W'(modulus);
   assign alu_sub = (state_ff == ST_RED);
   assign alu_b   = alu_sub ? div_ff : mcand_ff;

   mexp_alu #(
      .WIDTH(WW)
   ) u_alu (
      .a    (x_ff),
      .b    (alu_b),
      .sub  (alu_sub),
      .sum  (alu_sum),
      .carry(alu_carry)
   );

   always_comb begin
      state_in    = state_ff;
      x_in        = x_ff;
      acc_in      = acc_ff;
      sb_in       = sb_ff;
      exp_in      = exp_ff;
      mcand_in    = mcand_ff;
      mplier_in   = mplier_ff;
      div_in      = div_ff;
      step_in     = step_ff;
      dest_acc_in = dest_acc_ff;
      first_in    = first_ff;
      acc_done_in = acc_done_ff;
      err_in      = err_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctrl.start) begin
               if (mod_w == '0) begin
                  acc_in   = '0;
                  err_in   = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  // empty multiplier: drop straight into reducing the base
                  err_in      = 1'b0;
                  x_in        = WW'(W'(base));
                  exp_in      = W'(exponent);
                  acc_in      = WW'(1);
                  mplier_in   = '0;
                  dest_acc_in = 1'b0;
                  first_in    = 1'b1;
                  acc_done_in = 1'b0;
                  state_in    = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            if (mplier_ff == '0) begin
               div_in   = {mod_w, {W{1'b0}}};
               step_in  = '0;
               state_in = ST_RED;
            end else begin
               if (mplier_ff[0]) begin
                  x_in = alu_sum;
               end
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
            end
         end
         ST_RED: begin
            if (alu_carry) begin
               x_in = alu_sum;
            end
            div_in  = div_ff >> 1;
            step_in = STEP_W'(step_ff + 1'b1);
            if (step_ff == STEP_W'(W)) begin
               state_in = ST_WBACK;
            end
         end
         ST_WBACK: begin
            if (dest_acc_ff) begin
               acc_in      = x_ff;
               acc_done_in = 1'b1;
            end else begin
               sb_in       = x_ff;
               acc_done_in = 1'b0;
               // a squaring closes one exponent bit
               if (!first_ff) begin
                  exp_in = exp_ff >> 1;
               end
               first_in = 1'b0;
            end
            state_in = ST_CHOOSE;
         end
         ST_CHOOSE: begin
            if (exp_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               x_in      = '0;
               mplier_in = sb_ff;
               state_in  = ST_MUL;
               if (exp_ff[0] && !acc_done_ff) begin
                  mcand_in    = acc_ff;
                  dest_acc_in = 1'b1;
               end else begin
                  mcand_in    = sb_ff;
                  dest_acc_in = 1'b0;
               end
            end
         end
         ST_DONE: begin
            if (ctrl.take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         step_ff     <= '0;
         dest_acc_ff <= 1'b0;
         first_ff    <= 1'b0;
         acc_done_ff <= 1'b0;
         err_ff      <= 1'b0;
         acc_ff      <= '0;
         exp_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         step_ff     <= step_in;
         dest_acc_ff <= dest_acc_in;
         first_ff    <= first_in;
         acc_done_ff <= acc_done_in;
         err_ff      <= err_in;
         acc_ff      <= acc_in;
         exp_ff      <= exp_in;
      end
      x_ff      <= x_in;
      sb_ff     <= sb_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      div_ff    <= div_in;
   end

   assign stat.idle  = (state_ff == ST_IDLE);
   assign stat.done  = (state_ff == ST_DONE);
   assign stat.error = err_ff;
   assign result     = OPERAND_BITS'(acc_ff);

endmodule
`default_nettype wire
